/* rtl/core/mrs_pkg.sv */
// Shared constants, types and helpers for masked region statistics.
package mrs_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 27;
	localparam int FRAC_BITS_DEF   = 8;
	// divider steps cover 2*(|sum| << FRAC_BITS) + n; root steps half the scaled variance
	localparam int DIV_STEPS_DEF   = SAMPLE_BITS_DEF + COUNT_BITS_DEF + FRAC_BITS_DEF + 2;
	localparam int SQRT_STEPS_DEF  = SAMPLE_BITS_DEF + COUNT_BITS_DEF + FRAC_BITS_DEF;

	localparam logic [1:0] MODE_ALL   = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic accum;     // take in the accepted voxel
		logic fin_start; // latch sums, set up mean division and variance product
		logic div_step;  // one restoring-division step
		logic mul_step;  // one shift-add step of n*sumsq - sum^2
		logic sqrt_load; // take the mean, set up the root
		logic sqrt_step; // one square-root step
		logic sd_load;   // set up sigma division from the root
		logic sd_take;   // take sigma from the quotient
		logic res_load;  // capture the result register, clear sums
	} mrs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic neg_var;
	} mrs_sts_t;
endpackage

/* rtl/core/mrs_if.sv */
// Valid/ready stream interfaces for voxels, results and configuration.
interface mrs_in_if #(parameter int SAMPLE_BITS = 16) (input logic clk);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          mask_set;
	logic                          last_voxel;
	modport source (output valid, sample, mask_set, last_voxel, input ready);
	modport sink (input valid, sample, mask_set, last_voxel, output ready);
endinterface

interface mrs_out_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 27,
	parameter int FRAC_BITS   = 8
) (input logic clk);
	logic                                    valid;
	logic                                    ready;
	logic signed [SAMPLE_BITS-1:0]           minimum;
	logic signed [SAMPLE_BITS-1:0]           maximum;
	logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean;
	logic        [SAMPLE_BITS+FRAC_BITS-1:0] std_dev;
	logic        [COUNT_BITS-1:0]            selected_count;
	logic        [COUNT_BITS-1:0]            nonzero_count;
	logic                                    empty_res;
	logic                                    overflow;
	modport source (output valid, minimum, maximum, mean, std_dev, selected_count,
		nonzero_count, empty_res, overflow, input ready);
	modport sink (input valid, minimum, maximum, mean, std_dev, selected_count,
		nonzero_count, empty_res, overflow, output ready);
endinterface

interface mrs_cfg_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/core/mrs_ctrl.sv */
// Frame controller: accumulate, then sequence the mean, root and sigma steps.
module mrs_ctrl #(
	parameter int DIV_STEPS  = mrs_pkg::DIV_STEPS_DEF,
	parameter int SQRT_STEPS = mrs_pkg::SQRT_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  logic             res_busy,
	input  mrs_pkg::mrs_sts_t sts,
	output mrs_pkg::mrs_cmd_t cmd
);
	import mrs_pkg::*;

	localparam logic [3:0] ST_ACC   = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_MDIV  = 4'd2;
	localparam logic [3:0] ST_SQLD  = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_SDLD  = 4'd5;
	localparam logic [3:0] ST_SDIV  = 4'd6;
	localparam logic [3:0] ST_SDFIN = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;
	localparam int CW = $clog2((DIV_STEPS > SQRT_STEPS ? DIV_STEPS : SQRT_STEPS) + 1);

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          take;

	assign in_ready = (state_q == ST_ACC);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.accum = take;
		case (state_q)
			ST_LOAD:  cmd.fin_start = 1'b1;
			ST_MDIV: begin
				cmd.div_step = 1'b1;
				cmd.mul_step = 1'b1;
			end
			ST_SQLD:  cmd.sqrt_load = 1'b1;
			ST_SQRT:  cmd.sqrt_step = 1'b1;
			ST_SDLD:  cmd.sd_load   = 1'b1;
			ST_SDIV:  cmd.div_step  = 1'b1;
			ST_SDFIN: cmd.sd_take   = 1'b1;
			ST_DONE:  cmd.res_load  = !res_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_ACC: if (take && in_last) begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
				end
				ST_LOAD: state_q <= sts.empty ? ST_DONE : ST_MDIV;
				ST_MDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQLD;
					end
				end
				ST_SQLD: state_q <= sts.neg_var ? ST_DONE : ST_SQRT;
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SQRT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SDLD;
					end
				end
				ST_SDLD: state_q <= ST_SDIV;
				ST_SDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SDFIN;
					end
				end
				ST_SDFIN: state_q <= ST_DONE;
				ST_DONE: if (!res_busy) state_q <= ST_ACC;
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule

/* rtl/core/mrs_dp.sv */
// Datapath: running statistics, shift-add product, shared divider, bit-serial root.
module mrs_dp #(
	parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = mrs_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS   = mrs_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [1:0]                              mode,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	input  logic                                    mask_set,
	input  mrs_pkg::mrs_cmd_t                       cmd,
	output mrs_pkg::mrs_sts_t                       sts,
	output logic signed [SAMPLE_BITS-1:0]           r_min,
	output logic signed [SAMPLE_BITS-1:0]           r_max,
	output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] r_mean,
	output logic        [SAMPLE_BITS+FRAC_BITS-1:0] r_sd,
	output logic        [COUNT_BITS-1:0]            r_cnt,
	output logic        [COUNT_BITS-1:0]            r_nz,
	output logic                                    r_empty,
	output logic                                    r_ovf
);
	import mrs_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COUNT_BITS;
	localparam int MB   = SAMPLE_BITS + FRAC_BITS;
	localparam int SUMW = SB + CB;                 // signed sum
	localparam int SQW  = 2 * SB + CB;             // sum of squares
	localparam int PW   = CB + SQW;                // n*sumsq and sum^2
	localparam int AW   = PW + 1;                  // signed difference
	localparam int RW   = (PW + 2 * FRAC_BITS + 1) / 2; // root width
	localparam int XW   = 2 * RW;                  // scaled variance
	localparam int DW   = SUMW + FRAC_BITS + 2;    // divider dividend width
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};

	logic signed [SB-1:0]   min_q, max_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]         sq_q;
	logic [CB-1:0]          cnt_q, nz_q;
	logic                   seen_q, sat_q;

	logic          sel;
	logic [SB-1:0] mag;
	logic [2*SB-1:0] mag_sq;
	always_comb begin
		case (mode)
			MODE_SET:   sel = mask_set;
			MODE_CLEAR: sel = !mask_set;
			default:    sel = 1'b1;
		endcase
		mag = sample[SB-1] ? SB'(-sample) : SB'(sample);
	end
	assign mag_sq = (2*SB)'(mag) * (2*SB)'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; nz_q <= '0; seen_q <= 1'b0; sat_q <= 1'b0;
			sum_q <= '0; sq_q <= '0; min_q <= '0; max_q <= '0;
		end else if (cmd.res_load) begin
			cnt_q <= '0; nz_q <= '0; seen_q <= 1'b0; sat_q <= 1'b0;
			sum_q <= '0; sq_q <= '0; min_q <= '0; max_q <= '0;
		end else if (cmd.accum && sel) begin
			if (cnt_q == CMAX) sat_q <= 1'b1;
			else begin
				if (!seen_q || sample < min_q) min_q <= sample;
				if (!seen_q || sample > max_q) max_q <= sample;
				seen_q <= 1'b1;
				sum_q  <= sum_q + SUMW'(sample);
				sq_q   <= sq_q + SQW'(mag_sq);
				cnt_q  <= cnt_q + 1'b1;
				if (sample != '0) nz_q <= nz_q + 1'b1;
			end
		end
	end

	// final-phase registers
	logic [CB-1:0]   n_q;
	logic            neg_q;
	logic [SUMW-1:0] smag_n;
	logic [DW-1:0]   mdiv_n;      // 2*(|sum| << FRAC_BITS) + n, rounds the mean
	logic [PW-1:0]   ma_q, mb_q;  // shifted sumsq and |sum|
	logic [CB-1:0]   nb_q;        // multiplier bits of n
	logic [SUMW-1:0] sb_q;        // multiplier bits of |sum|
	logic [AW-1:0]   acc_q;       // n*sumsq - sum^2, two's complement
	logic [AW-1:0]   add_a, add_b;
	logic [DW-1:0]   dq_q;        // dividend shifting into quotient
	logic [CB:0]     drem_q;      // partial remainder
	logic [CB:0]     dden_q;      // divisor
	logic [CB+1:0]   dtrial;
	logic            dfit;
	logic [DW-1:0]   qneg;
	logic [XW-1:0]   sx_q;        // radicand, two bits a step
	logic [RW-1:0]   root_q;
	logic [RW-1:0]   srem_q;
	logic [RW+1:0]   strial, ssub;
	logic            sfit;
	logic [MB-1:0]   mean_q, sd_q;

	assign smag_n = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign mdiv_n = (DW'(smag_n) << (FRAC_BITS + 1)) + DW'(cnt_q);

	assign add_a = nb_q[0] ? AW'(ma_q) : '0;
	assign add_b = sb_q[0] ? AW'(mb_q) : '0;

	// divider step: rem = rem*2 + msb; subtract divisor if possible
	assign dtrial = {drem_q, dq_q[DW-1]};
	assign dfit   = dtrial >= (CB+2)'(dden_q);
	assign qneg   = ~dq_q + DW'(1);

	// square root: restoring bit-pair step
	assign strial = {srem_q, sx_q[XW-1 -: 2]};
	assign ssub   = {root_q, 2'b01};
	assign sfit   = strial >= ssub;

	always_ff @(posedge clk) begin
		if (cmd.fin_start) begin
			n_q    <= cnt_q;
			neg_q  <= sum_q[SUMW-1];
			dq_q   <= mdiv_n;
			drem_q <= '0;
			dden_q <= {cnt_q, 1'b0};
			ma_q   <= PW'(sq_q);
			nb_q   <= cnt_q;
			mb_q   <= PW'(smag_n);
			sb_q   <= smag_n;
			acc_q  <= '0;
			mean_q <= '0;
			sd_q   <= '0;
		end else begin
			if (cmd.div_step) begin
				dq_q   <= {dq_q[DW-2:0], dfit};
				drem_q <= (CB+1)'(dfit ? dtrial - (CB+2)'(dden_q) : dtrial);
			end
			if (cmd.sd_load) begin
				dq_q   <= DW'(root_q);
				drem_q <= '0;
				dden_q <= (CB+1)'(n_q);
			end
			if (cmd.mul_step) begin
				acc_q <= acc_q + add_a - add_b;
				ma_q  <= ma_q << 1;
				nb_q  <= nb_q >> 1;
				mb_q  <= mb_q << 1;
				sb_q  <= sb_q >> 1;
			end
			if (cmd.sqrt_load) begin
				mean_q <= MB'(neg_q ? qneg : dq_q);
				sx_q   <= XW'(acc_q[PW-1:0]) << (2 * FRAC_BITS);
				root_q <= '0;
				srem_q <= '0;
			end
			if (cmd.sqrt_step) begin
				sx_q   <= sx_q << 2;
				srem_q <= RW'(sfit ? strial - ssub : strial);
				root_q <= {root_q[RW-2:0], sfit};
			end
			if (cmd.sd_take)
				sd_q <= (dq_q > DW'({MB{1'b1}})) ? {MB{1'b1}} : MB'(dq_q);
		end
	end

	assign sts.empty   = (cnt_q == '0);
	assign sts.neg_var = acc_q[AW-1];
	assign r_min = min_q; assign r_max = max_q; assign r_mean = mean_q;
	assign r_sd = sd_q; assign r_cnt = cnt_q; assign r_nz = nz_q;
	assign r_empty = (cnt_q == '0); assign r_ovf = sat_q;
endmodule

/* rtl/core/masked_region_statistics.sv */
// Top level of masked region statistics: register, controller, datapath, result.
// Sequence from the last voxel to result valid with default widths: a 53-step mean
//   division with the variance product alongside, a 51-step root, a 53-step sigma
//   division and single setup states between; an empty selection skips to the result.
// Throughput: one voxel per cycle inside a frame; input closed from the last voxel until
//   the result is loaded, and longer while a previous result is stalled.
// Reset: arst_n clears mode, sums, counts and the result valid asynchronously.
module masked_region_statistics #(
	parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = mrs_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS   = mrs_pkg::FRAC_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	mrs_in_if.sink   in_ch,
	mrs_out_if.source out_ch,
	mrs_cfg_if.sink  cfg
);
	import mrs_pkg::*;

	// step counts follow the datapath widths
	localparam int DIV_STEPS  = SAMPLE_BITS + COUNT_BITS + FRAC_BITS + 2;
	localparam int SQRT_STEPS = SAMPLE_BITS + COUNT_BITS + FRAC_BITS;

	logic [1:0] mode_q;
	mrs_cmd_t   cmd;
	mrs_sts_t   sts;
	logic       res_v_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_ALL;
		else if (cfg.valid) mode_q <= cfg.data;
	end

	logic signed [SAMPLE_BITS-1:0] r_min, r_max;
	logic signed [SAMPLE_BITS+FRAC_BITS-1:0] r_mean;
	logic [SAMPLE_BITS+FRAC_BITS-1:0] r_sd;
	logic [COUNT_BITS-1:0] r_cnt, r_nz;
	logic r_empty, r_ovf;

	mrs_ctrl #(.DIV_STEPS(DIV_STEPS), .SQRT_STEPS(SQRT_STEPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_last(in_ch.last_voxel),
		.in_ready(in_ch.ready), .res_busy(res_v_q && !out_ch.ready), .sts(sts), .cmd(cmd)
	);

	mrs_dp #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .mode(mode_q), .sample(in_ch.sample),
		.mask_set(in_ch.mask_set), .cmd(cmd), .sts(sts), .r_min(r_min), .r_max(r_max),
		.r_mean(r_mean), .r_sd(r_sd), .r_cnt(r_cnt), .r_nz(r_nz), .r_empty(r_empty),
		.r_ovf(r_ovf)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (cmd.res_load) res_v_q <= 1'b1;
		else if (out_ch.ready) res_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_ch.minimum <= r_empty ? '0 : r_min;
			out_ch.maximum <= r_empty ? '0 : r_max;
			out_ch.mean <= r_mean;
			out_ch.std_dev <= r_sd;
			out_ch.selected_count <= r_cnt;
			out_ch.nonzero_count <= r_nz;
			out_ch.empty_res <= r_empty;
			out_ch.overflow <= r_ovf;
		end
	end
	assign out_ch.valid = res_v_q;

	// no new result while one is stalled
	assert property (@(posedge clk) disable iff (!arst_n) res_v_q && !out_ch.ready |-> !cmd.res_load)
		else $error("result overwritten");
	// input closed during the frame tail
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_step |-> !in_ch.ready)
		else $error("input open during division");
endmodule
